// ===== rtl/core/civ_pkg.sv =====
// Shared types, codes and constants of the Chebyshev low-pass IIR unit.
// Holds the control word layout, the microprogram ROM and the binomial table.
// No dependencies.
package civ_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   localparam int STATE_W   = 48;
   localparam int NUM_FB    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int BINOM_W   = 8;
   localparam int MAX_ORDER = 8;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FB1  = 3'd1;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_GAIN0 = 3'd1;
   localparam logic [STEP_W-1:0] STEP_YOUT  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TAP_A = 3'd3;
   localparam logic [STEP_W-1:0] STEP_TAP_B = 3'd4;
   localparam logic [STEP_W-1:0] STEP_FIN   = 3'd5;

   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_GAIN = 2'd1;
   localparam logic [1:0] MUL_FB   = 2'd2;

   localparam logic [2:0] SEQ_NEXT     = 3'd0;
   localparam logic [2:0] SEQ_WAIT_IN  = 3'd1;
   localparam logic [2:0] SEQ_LOOP     = 3'd2;
   localparam logic [2:0] SEQ_WAIT_OUT = 3'd3;
   localparam logic [2:0] SEQ_JUMP     = 3'd4;

   typedef logic signed [COEF_W-1:0] tap_type;

   typedef struct packed {
      logic              take_in;
      logic [1:0]        mul_sel;
      logic              cx_ld;
      logic              t_inc;
      logic              y_ld;
      logic              acc_ld;
      logic              d_wr;
      logic              out_ld;
      logic [2:0]        seq;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic in_xfer;
      logic last_tap;
      logic out_free;
   } status_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.take_in = 1'b1;
            w.seq     = SEQ_WAIT_IN;
         end
         STEP_GAIN0: begin
            w.mul_sel = MUL_GAIN;
            w.cx_ld   = 1'b1;
            w.t_inc   = 1'b1;
            w.seq     = SEQ_NEXT;
         end
         STEP_YOUT: begin
            w.y_ld = 1'b1;
            w.seq  = SEQ_NEXT;
         end
         STEP_TAP_A: begin
            w.mul_sel = MUL_GAIN;
            w.d_wr    = 1'b1;
            w.seq     = SEQ_NEXT;
         end
         STEP_TAP_B: begin
            w.mul_sel = MUL_FB;
            w.acc_ld  = 1'b1;
            w.cx_ld   = 1'b1;
            w.t_inc   = 1'b1;
            w.seq     = SEQ_LOOP;
            w.target  = STEP_TAP_A;
         end
         STEP_FIN: begin
            w.d_wr   = 1'b1;
            w.out_ld = 1'b1;
            w.seq    = SEQ_WAIT_OUT;
            w.target = STEP_IDLE;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Pascal row n, entry k; zero outside the row
   function automatic logic [BINOM_W-1:0] binom_coef(input int n, input int k);
      logic [BINOM_W-1:0] row [0:MAX_ORDER];
      for (int j = 0; j <= MAX_ORDER; j++) begin
         row[j] = (j == 0) ? BINOM_W'(1) : '0;
      end
      for (int r = 1; r <= MAX_ORDER; r++) begin
         if (r <= n) begin
            for (int j = MAX_ORDER; j >= 1; j--) begin
               row[j] = row[j] + row[j-1];
            end
         end
      end
      if (k < 0 || k > n) begin
         return '0;
      end
      return row[k];
   endfunction

endpackage

// ===== rtl/core/civ_req_if.sv =====
// Input sample channel of the Chebyshev low-pass IIR unit.
// Depends on civ_pkg for the sample width.
interface civ_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [civ_pkg::SAMPLE_W-1:0]   sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/core/civ_rsp_if.sv =====
// Result channel of the Chebyshev low-pass IIR unit.
// Depends on civ_pkg for the sample width.
interface civ_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [civ_pkg::SAMPLE_W-1:0]   sample_out;
   logic                                  clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== rtl/core/civ_csr_if.sv =====
// Register write channel of the Chebyshev low-pass IIR unit.
// Depends on civ_pkg for index and data widths.
interface civ_csr_if;
   logic                              valid;
   logic                              ready;
   logic [civ_pkg::CSR_IDX_W-1:0]     index;
   logic [civ_pkg::COEF_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/civ_csr_regs.sv =====
// Gain and feedback tap registers of the Chebyshev low-pass IIR unit.
// Depends on civ_pkg and civ_csr_if.
module civ_csr_regs (
   input  logic                        clock,
   input  logic                        reset,
   civ_csr_if.sink                     csr_ch,
   output logic [civ_pkg::COEF_W-1:0]  gain,
   output civ_pkg::tap_type            fb_coef [civ_pkg::NUM_FB]
);
   import civ_pkg::*;

   logic [COEF_W-1:0] gain_ff, gain_in;
   tap_type           coef_ff [NUM_FB];
   tap_type           coef_in [NUM_FB];
   logic              wr_xfer;

   assign csr_ch.ready = 1'b1;
   assign wr_xfer      = csr_ch.valid;

   always_comb begin
      gain_in = gain_ff;
      for (int j = 0; j < NUM_FB; j++) begin
         coef_in[j] = coef_ff[j];
      end
      if (wr_xfer) begin
         if (csr_ch.index == REG_GAIN) begin
            gain_in = csr_ch.data;
         end
         for (int j = 0; j < NUM_FB; j++) begin
            if (csr_ch.index == REG_FB1 + CSR_IDX_W'(j)) begin
               coef_in[j] = csr_ch.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         for (int j = 0; j < NUM_FB; j++) begin
            coef_ff[j] <= '0;
         end
      end else begin
         gain_ff <= gain_in;
         for (int j = 0; j < NUM_FB; j++) begin
            coef_ff[j] <= coef_in[j];
         end
      end
   end

   assign gain = gain_ff;
   always_comb begin
      for (int j = 0; j < NUM_FB; j++) begin
         fb_coef[j] = coef_ff[j];
      end
   end

endmodule

// ===== rtl/core/civ_sequencer.sv =====
// Microprogram counter of the Chebyshev low-pass IIR unit.
// Depends on civ_pkg for the control word ROM and the status struct.
module civ_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  civ_pkg::status_type    stat,
   output civ_pkg::ucode_type     ctrl
);
   import civ_pkg::*;

   logic [STEP_W-1:0] pc_ff, pc_in;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.seq)
         SEQ_NEXT:     pc_in = pc_ff + STEP_W'(1);
         SEQ_WAIT_IN:  pc_in = stat.in_xfer ? pc_ff + STEP_W'(1) : pc_ff;
         SEQ_LOOP:     pc_in = stat.last_tap ? pc_ff + STEP_W'(1) : ctrl.target;
         SEQ_WAIT_OUT: pc_in = stat.out_free ? ctrl.target : pc_ff;
         SEQ_JUMP:     pc_in = ctrl.target;
         default:      pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/core/civ_datapath.sv =====
// Datapath of the Chebyshev low-pass IIR unit: shared multiplier, delay state,
// rounding, saturation and output register. Depends on civ_pkg and the channel interfaces.
module civ_datapath #(
   parameter int ORDER = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  civ_pkg::ucode_type          ctrl,
   output civ_pkg::status_type         stat,
   civ_req_if.sink                     req_ch,
   civ_rsp_if.source                   rsp_ch,
   input  logic [civ_pkg::COEF_W-1:0]  gain,
   input  civ_pkg::tap_type            fb_coef [civ_pkg::NUM_FB]
);
   import civ_pkg::*;

   localparam int TW     = $clog2(ORDER + 1);
   localparam int IDXW   = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int CX_W   = 24;
   localparam int PROD_W = COEF_W + 1 + CX_W;
   localparam int ACC_W  = STATE_W + 2;
   localparam int P_W    = PROD_W - 8;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(128);
   localparam logic signed [ACC_W-1:0]  Y_HALF   = ACC_W'(64'd8388608);
   localparam logic signed [PROD_W-1:0] D_MAX    = PROD_W'(64'h7FFF_FFFF_FFFF);
   localparam logic signed [PROD_W-1:0] D_MIN    = -D_MAX - PROD_W'(1);
   localparam logic signed [25:0]       Y_MAX    = 26'sd32767;
   localparam logic signed [25:0]       Y_MIN    = -26'sd32768;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [CX_W-1:0]     cx_ff, cx_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic                       clip_ff, clip_in;
   logic [TW-1:0]              t_ff, t_in;
   logic [IDXW-1:0]            wi_ff, wi_in;
   logic                       pend_ff, pend_in;
   logic signed [STATE_W-1:0]  d_ff [ORDER];
   logic signed [STATE_W-1:0]  d_in [ORDER];
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_clip_ff, out_clip_in;

   logic                       in_xfer;
   logic                       out_free;
   logic [BINOM_W-1:0]         coef_c;
   logic signed [CX_W:0]       cx_full;
   tap_type                    a_sel;
   logic signed [COEF_W:0]     opa;
   logic signed [CX_W-1:0]     opb;
   logic signed [PROD_W-1:0]   mul_out;
   logic signed [PROD_W-1:0]   rnd_sum;
   logic signed [P_W-1:0]      p_rnd;
   logic signed [STATE_W-1:0]  d_rd;
   logic signed [ACC_W-1:0]    s_sum;
   logic signed [25:0]         y_wide;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic                       y_clip;
   logic signed [PROD_W-1:0]   diff;
   logic signed [STATE_W-1:0]  nd;

   assign req_ch.ready = ctrl.take_in;
   assign in_xfer      = req_ch.valid && ctrl.take_in;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign stat.in_xfer  = in_xfer;
   assign stat.last_tap = (int'(t_ff) == ORDER);
   assign stat.out_free = out_free;

   assign coef_c  = binom_coef(ORDER, int'(t_ff) + 1);
   assign cx_full = x_ff * $signed({1'b0, coef_c});

   always_comb begin
      a_sel = '0;
      for (int j = 0; j < NUM_FB; j++) begin
         if (int'(t_ff) == j + 1) begin
            a_sel = fb_coef[j];
         end
      end
   end

   always_comb begin
      case (ctrl.mul_sel)
         MUL_GAIN: begin
            opa = $signed({1'b0, gain});
            opb = cx_ff;
         end
         MUL_FB: begin
            opa = {a_sel[COEF_W-1], a_sel};
            opb = {{(CX_W - SAMPLE_W){y_ff[SAMPLE_W-1]}}, y_ff};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign mul_out = opa * opb;

   assign rnd_sum = prod_ff + RND_HALF;
   assign p_rnd   = rnd_sum[PROD_W-1:8];
   assign d_rd    = (int'(t_ff) < ORDER) ? d_ff[t_ff[IDXW-1:0]] : '0;

   assign s_sum  = {{(ACC_W - P_W){p_rnd[P_W-1]}}, p_rnd}
                 + {{(ACC_W - STATE_W){d_ff[0][STATE_W-1]}}, d_ff[0]} + Y_HALF;
   assign y_wide = s_sum[ACC_W-1:24];

   always_comb begin
      y_clip = 1'b0;
      y_sat  = y_wide[SAMPLE_W-1:0];
      if (y_wide > Y_MAX) begin
         y_sat  = Y_MAX[SAMPLE_W-1:0];
         y_clip = 1'b1;
      end else if (y_wide < Y_MIN) begin
         y_sat  = Y_MIN[SAMPLE_W-1:0];
         y_clip = 1'b1;
      end
   end

   assign diff = {{(PROD_W - ACC_W){acc_ff[ACC_W-1]}}, acc_ff} - prod_ff;

   always_comb begin
      if (diff > D_MAX) begin
         nd = D_MAX[STATE_W-1:0];
      end else if (diff < D_MIN) begin
         nd = D_MIN[STATE_W-1:0];
      end else begin
         nd = diff[STATE_W-1:0];
      end
   end

   always_comb begin
      x_in          = x_ff;
      cx_in         = cx_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      y_in          = y_ff;
      clip_in       = clip_ff;
      t_in          = t_ff;
      wi_in         = wi_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_clip_in   = out_clip_ff;
      for (int j = 0; j < ORDER; j++) begin
         d_in[j] = d_ff[j];
      end

      if (in_xfer) begin
         x_in    = req_ch.sample_in;
         cx_in   = {{(CX_W - SAMPLE_W){req_ch.sample_in[SAMPLE_W-1]}}, req_ch.sample_in};
         t_in    = '0;
         pend_in = 1'b0;
      end
      if (ctrl.mul_sel != MUL_NONE) begin
         prod_in = mul_out;
      end
      if (ctrl.cx_ld) begin
         cx_in = cx_full[CX_W-1:0];
      end
      if (ctrl.t_inc) begin
         t_in = t_ff + TW'(1);
      end
      if (ctrl.y_ld) begin
         y_in    = y_sat;
         clip_in = y_clip;
      end
      if (ctrl.acc_ld) begin
         acc_in  = {{(ACC_W - P_W){p_rnd[P_W-1]}}, p_rnd}
                 + {{(ACC_W - STATE_W){d_rd[STATE_W-1]}}, d_rd};
         wi_in   = IDXW'(t_ff - TW'(1));
         pend_in = 1'b1;
      end
      if (ctrl.d_wr && pend_ff) begin
         d_in[wi_ff] = nd;
      end
      if (ctrl.out_ld && out_free) begin
         out_valid_in  = 1'b1;
         out_sample_in = y_ff;
         out_clip_in   = clip_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < ORDER; j++) begin
            d_ff[j] <= '0;
         end
      end else begin
         t_ff         <= t_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         for (int j = 0; j < ORDER; j++) begin
            d_ff[j] <= d_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      cx_ff         <= cx_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      y_ff          <= y_in;
      clip_ff       <= clip_in;
      wi_ff         <= wi_in;
      out_sample_ff <= out_sample_in;
      out_clip_ff   <= out_clip_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_sample_ff;
   assign rsp_ch.clipped    = out_clip_ff;

endmodule

// ===== rtl/core/chebyshev_lowpass_iir_unit.sv =====
// Top level of the Chebyshev low-pass IIR unit: registers, sequencer, datapath.
// Depends on civ_pkg, the channel interfaces, civ_csr_regs, civ_sequencer, civ_datapath.
//
//   channel  direction  payload                         transfer
//   req_ch   in         sample_in[15:0]                 valid && ready
//   rsp_ch   out        sample_out[15:0], clipped       valid && ready
//   csr_ch   in         index[2:0], data[31:0]          valid && ready, ready tied high
//
// A new sample is taken only once the last one has passed every tap; the single
// 33x24 multiplier forms one gain product and one feedback product per tap.
// A result stays in the output register until taken; the next sample is
// taken meanwhile, and the sequencer holds only if a second result is ready.
// Reset clears taps, gain, delay state and the output valid.
module chebyshev_lowpass_iir_unit #(
   parameter int ORDER = 4
) (
   input  logic        clock,
   input  logic        reset,
   civ_req_if.sink     req_ch,
   civ_rsp_if.source   rsp_ch,
   civ_csr_if.sink     csr_ch
);
   import civ_pkg::*;

   logic [COEF_W-1:0] gain;
   tap_type           fb_coef [NUM_FB];
   ucode_type         ctrl;
   status_type        stat;

   civ_csr_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .gain    (gain),
      .fb_coef (fb_coef)
   );

   civ_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   civ_datapath #(
      .ORDER (ORDER)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .stat    (stat),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .gain    (gain),
      .fb_coef (fb_coef)
   );

endmodule

// ===== dv/chebyshev_lowpass_iir_unit_tb.sv =====
// Testbench of chebyshev_lowpass_iir_unit: a directed table, then random phases.
// Results are checked against a bit-true filter predictor kept in this file.
// Depends on civ_pkg and the civ_req_if, civ_rsp_if and civ_csr_if interfaces.
`timescale 1ns / 100ps

module chebyshev_lowpass_iir_unit_tb;
   import civ_pkg::*;

   localparam int DUT_ORDER       = 4;
   localparam int NUM_REGS        = NUM_FB + 1;
   localparam int TAP_IDX_W       = $clog2(NUM_FB);
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 2 * (2 * DUT_ORDER + 4);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_COUNT     = 6;
   localparam int PHASE_ITEMS     = 105;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DIRECTED_COUNT  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FB2          = REG_FB1 + 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FB3          = REG_FB1 + 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB4          = REG_FB1 + 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO  = REG_FB4 + 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_MID = REG_FB4 + 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI  = REG_FB4 + 3'd3;

   localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SMP_ZERO = 16'sh0000;
   localparam logic signed [SAMPLE_W-1:0] SMP_ONE  = 16'sh0001;
   localparam logic signed [SAMPLE_W-1:0] SMP_NEG1 = 16'shFFFF;

   localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
   localparam longint STATE_MIN = -STATE_MAX - 1;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {TAKE_ALL, TAKE_HALF, TAKE_QUARTER} sink_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } filter_result_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       index;
      logic [COEF_W-1:0]          data;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       check;
      logic signed [SAMPLE_W-1:0] want_out;
      logic                       want_clip;
   } dir_row_type;

   dir_row_type directed_rows [DIRECTED_COUNT] = '{
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b1, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b1, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ZERO, 1'b1, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_NEG1, 1'b1, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_GAIN, 32'hFFFF_FFFF, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b1, SMP_MAX, 1'b1},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b1, SMP_MIN, 1'b1},
      '{ROW_WRITE, REG_UNMAPPED_LO, 32'hFFFF_FFFF, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_UNMAPPED_MID, 32'h1234_5678, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_UNMAPPED_HI, 32'h8000_0000, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ONE, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_FB1, 32'h7FFF_FFFF, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_FB2, 32'h8000_0000, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_FB3, 32'h7FFF_FFFF, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_FB4, 32'h8000_0000, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ONE, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_GAIN, 32'h0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_WRITE, REG_GAIN, 32'h0000_0001, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MIN, 1'b0, SMP_ZERO, 1'b0},
      '{ROW_SAMPLE, REG_GAIN, 32'h0, SMP_MAX, 1'b0, SMP_ZERO, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   civ_req_if req_ch();
   civ_rsp_if rsp_ch();
   civ_csr_if csr_ch();

   chebyshev_lowpass_iir_unit #(
      .ORDER (DUT_ORDER)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [COEF_W-1:0]          gain_reg;
   tap_type                    feedback_taps [NUM_FB];
   longint                     delay_state [DUT_ORDER];
   filter_result_type          pending_results [$];
   filter_result_type          oldest_result;
   int unsigned                burst_left;
   int unsigned                cycle_count;
   int unsigned                error_count;
   bit                         hold_off_request;

   always #6 clock = ~clock;

   function automatic longint pascal_weight(input int k);
      longint c;
      c = 1;
      for (int j = 0; j < k; j++) begin
         c = c * (DUT_ORDER - j) / (j + 1);
      end
      return c;
   endfunction

   function automatic longint clamp48(input longint v);
      if (v > STATE_MAX) begin
         return STATE_MAX;
      end
      if (v < STATE_MIN) begin
         return STATE_MIN;
      end
      return v;
   endfunction

   // advance the filter by one sample and return its output
   function automatic filter_result_type filter_step(input logic signed [SAMPLE_W-1:0] x);
      longint            fwd [DUT_ORDER+1];
      longint            acc;
      longint            y;
      longint            fb;
      filter_result_type res;
      for (int i = 0; i <= DUT_ORDER; i++) begin
         fwd[i] = (longint'(gain_reg) * pascal_weight(i) * longint'(x) + 128) >>> 8;
      end
      acc = fwd[0] + delay_state[0];
      y = (acc + (64'sd1 <<< 23)) >>> 24;
      res.clipped = 1'b0;
      if (y > longint'(SMP_MAX)) begin
         y = SMP_MAX;
         res.clipped = 1'b1;
      end else if (y < longint'(SMP_MIN)) begin
         y = SMP_MIN;
         res.clipped = 1'b1;
      end
      for (int i = 0; i < DUT_ORDER; i++) begin
         fb = (i < NUM_FB) ? longint'(feedback_taps[i]) : 64'sd0;
         if (i < DUT_ORDER - 1) begin
            delay_state[i] = clamp48(fwd[i+1] + delay_state[i+1] - fb * y);
         end else begin
            delay_state[i] = clamp48(fwd[i+1] - fb * y);
         end
      end
      res.sample_out = SAMPLE_W'(y);
      return res;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == REG_GAIN) begin
         gain_reg = data;
      end else if (idx >= REG_FB1 && idx <= REG_FB4) begin
         feedback_taps[TAP_IDX_W'(idx - REG_FB1)] = data;
      end
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input bit typed,
                              input filter_result_type typed_res);
      filter_result_type predicted;
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = filter_step(x);
      pending_results.push_back(typed ? typed_res : predicted);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   // drop the request and wait for the unit to go idle
   task automatic settle_filter();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [COEF_W-1:0]          phase_regs [NUM_REGS];
      logic signed [SAMPLE_W-1:0] x;
      filter_result_type          typed_res;
      int unsigned                pick;
      reset            = 1'b1;
      req_ch.valid     <= 1'b0;
      csr_ch.valid     <= 1'b0;
      gain_reg         = '0;
      burst_left       = 0;
      for (int j = 0; j < NUM_FB; j++) begin
         feedback_taps[j] = '0;
      end
      for (int j = 0; j < DUT_ORDER; j++) begin
         delay_state[j] = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            settle_filter();
            csr_write(directed_rows[r].index, directed_rows[r].data);
         end else begin
            typed_res.sample_out = directed_rows[r].want_out;
            typed_res.clipped    = directed_rows[r].want_clip;
            send_sample(directed_rows[r].sample, directed_rows[r].check, typed_res);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_filter();
         for (int r = 0; r < NUM_REGS; r++) begin
            if (r == 0) begin
               phase_regs[r] = (p % 2 == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000);
            end else if (p % 3 == 0) begin
               phase_regs[r] = $urandom();
            end else begin
               phase_regs[r] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            end
            csr_write(REG_GAIN + CSR_IDX_W'(r), phase_regs[r]);
         end
         if (p % 2 == 1) begin
            csr_write(REG_UNMAPPED_LO + CSR_IDX_W'($urandom_range(0, 2)), $urandom());
         end
         if (p == 2) begin
            hold_off_request = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0:       x = SMP_MAX;
               1:       x = SMP_MIN;
               2:       x = SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
               default: x = SAMPLE_W'($urandom());
            endcase
            typed_res = '0;
            send_sample(x, 1'b0, typed_res);
         end
      end
      settle_filter();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transfer: sample_out %0d clipped %0b",
                   rsp_ch.sample_out, rsp_ch.clipped);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_ch.sample_out !== oldest_result.sample_out) begin
               $error("sample_out: expected %0d, actual %0d",
                      oldest_result.sample_out, rsp_ch.sample_out);
               error_count++;
            end
            if (rsp_ch.clipped !== oldest_result.clipped) begin
               $error("clipped: expected %0b, actual %0b",
                      oldest_result.clipped, rsp_ch.clipped);
               error_count++;
            end
         end
      end
   end

   initial begin
      sink_mode_type mode;
      int unsigned   stretch;
      bit            take;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode    = sink_mode_type'($urandom_range(0, 2));
         stretch = $urandom_range(8, 64);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_off_request) begin
               rsp_ch.ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off_request = 1'b0;
            end
            case (mode)
               TAKE_ALL:  take = 1'b1;
               TAKE_HALF: take = ($urandom_range(0, 1) == 1);
               default:   take = ($urandom_range(0, 3) == 0);
            endcase
            rsp_ch.ready <= take;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/civ_pkg.sv
rtl/core/civ_req_if.sv
rtl/core/civ_rsp_if.sv
rtl/core/civ_csr_if.sv
rtl/core/civ_csr_regs.sv
rtl/core/civ_sequencer.sv
rtl/core/civ_datapath.sv
rtl/core/chebyshev_lowpass_iir_unit.sv
dv/chebyshev_lowpass_iir_unit_tb.sv
